@@ rtl/core/rmts_pkg.sv @@
// shared constants, types and bound table for the rate-monotonic scheduler
`default_nettype none

package rmts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int FRAC_BITS = 16;

  localparam int TIME_W = 16;
  localparam int IDX_W  = 4;
  localparam int CT_W   = 20;
  localparam int UTIL_W = 8 + FRAC_BITS;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // dividend is burst shifted up by the fraction bits, padded to an even width
  localparam int DVD_W     = TIME_W + FRAC_BITS;
  localparam int DIV_STEPS = (DVD_W + 1) / 2;
  localparam int QUO_W     = 2 * DIV_STEPS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int BOUND_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int BOUND_SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  typedef struct packed {
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] deadline;
    logic [IDX_W-1:0]  index;
  } task_entry_t;

  // floor(n(2^(1/n)-1) * 2^16) for n = 0..64
  localparam logic [16:0] BOUND_Q16 [65] = '{
    17'd0,
    17'd65536, 17'd54291, 17'd51102, 17'd49599, 17'd48725, 17'd48154, 17'd47751, 17'd47452,
    17'd47221, 17'd47037, 17'd46887, 17'd46763, 17'd46658, 17'd46569, 17'd46492, 17'd46424,
    17'd46364, 17'd46312, 17'd46264, 17'd46222, 17'd46184, 17'd46149, 17'd46117, 17'd46088,
    17'd46061, 17'd46037, 17'd46014, 17'd45993, 17'd45973, 17'd45954, 17'd45937, 17'd45921,
    17'd45906, 17'd45892, 17'd45878, 17'd45866, 17'd45854, 17'd45842, 17'd45832, 17'd45821,
    17'd45812, 17'd45803, 17'd45794, 17'd45785, 17'd45777, 17'd45770, 17'd45762, 17'd45755,
    17'd45748, 17'd45742, 17'd45736, 17'd45730, 17'd45724, 17'd45718, 17'd45713, 17'd45708,
    17'd45703, 17'd45698, 17'd45693, 17'd45689, 17'd45685, 17'd45680, 17'd45676, 17'd45672
  };

  // liu-layland bound for n tasks at the working fraction width
  function automatic logic [UTIL_W-1:0] bound_for(input logic [CNT_W-1:0] n);
    logic [6:0]  idx;
    logic [47:0] wide;
    idx  = (32'(n) > 32'd64) ? 7'd64 : 7'(n);
    wide = (48'(BOUND_Q16[idx]) << BOUND_SHL) >> BOUND_SHR;
    return wide[UTIL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rate_monotonic_task_scheduler.sv @@
// rate-monotonic task scheduler with liu-layland schedulability test
//
// input channel (in_valid/in_ready): one task per transaction, carrying burst,
// period, deadline and a last-task mark. each stored task gets its arrival
// index. a stored task with a nonzero period is accepted, passed through the
// radix-4 utilization divider (two quotient bits per cycle) and accumulated;
// in_ready is high only while the block is idle.
// a task arriving when the store is full is dropped, but its mark still ends
// the set.
// after the marked task the store is sorted by period in place: each outer pass
// loads entry i, makes one read per compare on the task memory's single read
// port and writes entry i back. then one result transaction per stored task
// comes out in period order, the next one read only once the last is taken;
// a stalled result just holds in the output register until taken.
// after the final result of a set, the count and utilization sum clear.
// reset (rst_n low, synchronous) empties the set; the task memory is not
// cleared, since only entries written in the current set are ever read.
`default_nettype none

module rate_monotonic_task_scheduler (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rmts_pkg::TIME_W-1:0] in_burst_time,
  input  wire logic [rmts_pkg::TIME_W-1:0] in_task_period,
  input  wire logic [rmts_pkg::TIME_W-1:0] in_task_deadline,
  input  wire logic                        in_last_task,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rmts_pkg::IDX_W-1:0]       out_task_index,
  output logic [rmts_pkg::CT_W-1:0]        out_completion_time,
  output logic [rmts_pkg::CT_W-1:0]        out_waiting_time,
  output logic                             out_deadline_missed,
  output logic [rmts_pkg::UTIL_W-1:0]      out_utilization,
  output logic                             out_schedulable,
  output logic                             out_last_result
);
  import rmts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_ACC,
    S_SORT_LDI,
    S_SORT_GETI,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_WB,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD
  } state_t;

  // restoring divide step: returns {quotient bit, new remainder}
  function automatic logic [TIME_W:0] div_step(input logic [TIME_W-1:0] rem,
                                               input logic              din,
                                               input logic [TIME_W-1:0] dvs);
    logic [TIME_W:0] sh;
    logic [TIME_W:0] diff;
    sh   = {rem, din};
    diff = sh - {1'b0, dvs};
    if (!diff[TIME_W]) begin
      return {1'b1, diff[TIME_W-1:0]};
    end
    return {1'b0, sh[TIME_W-1:0]};
  endfunction

  // task memory, one write and one registered read port
  task_entry_t mem [MAX_TASKS];
  task_entry_t rd_data_r;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_wa;
  task_entry_t mem_wd;
  logic        mem_re;
  logic [ADDR_W-1:0] mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // control and datapath registers
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [UTIL_W-1:0]   sum_r, sum_nxt;
  logic [UTIL_W-1:0]   term_r, term_nxt;
  logic                sched_r, sched_nxt;
  logic                last_r, last_nxt;
  logic [TIME_W-1:0]   per_r, per_nxt;
  logic [QUO_W-1:0]    dvd_r, dvd_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  task_entry_t         cur_r, cur_nxt;
  logic [CT_W-1:0]     ct_r, ct_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [CT_W-1:0]     out_ct_r, out_ct_nxt;
  logic [CT_W-1:0]     out_wait_r, out_wait_nxt;
  logic                out_miss_r, out_miss_nxt;
  logic                out_last_r, out_last_nxt;

  logic [TIME_W:0]     st1, st2;
  logic [QUO_W-1:0]    quo_fin;
  logic [UTIL_W:0]     acc;
  logic [CT_W:0]       ct_sum;
  logic [CT_W-1:0]     ct_sat;
  logic                full;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    term_nxt      = term_r;
    sched_nxt     = sched_r;
    last_nxt      = last_r;
    per_nxt       = per_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    ct_nxt        = ct_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_ct_nxt    = out_ct_r;
    out_wait_nxt  = out_wait_r;
    out_miss_nxt  = out_miss_r;
    out_last_nxt  = out_last_r;

    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;

    full = (count_r == CNT_W'(MAX_TASKS));

    st1     = div_step(rem_r, dvd_r[QUO_W-1], per_r);
    st2     = div_step(st1[TIME_W-1:0], dvd_r[QUO_W-2], per_r);
    quo_fin = {quo_r[QUO_W-3:0], st1[TIME_W], st2[TIME_W]};

    acc = {1'b0, sum_r} + {1'b0, term_r};

    ct_sum = {1'b0, ct_r} + (CT_W+1)'(rd_data_r.burst);
    ct_sat = ct_sum[CT_W] ? '1 : ct_sum[CT_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last_task;
          per_nxt  = in_task_period;
          dvd_nxt  = QUO_W'(in_burst_time) << FRAC_BITS;
          quo_nxt  = '0;
          rem_nxt  = '0;
          step_nxt = STEP_W'(DIV_STEPS - 1);
          if (full) begin
            // dropped task adds nothing
            term_nxt  = '0;
            state_nxt = S_ACC;
          end else begin
            mem_we    = 1'b1;
            mem_wa    = count_r[ADDR_W-1:0];
            mem_wd    = '{burst: in_burst_time, period: in_task_period,
                          deadline: in_task_deadline, index: IDX_W'(count_r)};
            count_nxt = count_r + CNT_W'(1);
            if (in_task_period == '0) begin
              term_nxt  = '1;
              state_nxt = S_ACC;
            end else begin
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        rem_nxt = st2[TIME_W-1:0];
        dvd_nxt = dvd_r << 2;
        quo_nxt = quo_fin;
        if (step_r == '0) begin
          term_nxt  = (|quo_fin[QUO_W-1:UTIL_W]) ? '1 : quo_fin[UTIL_W-1:0];
          state_nxt = S_ACC;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end

      S_ACC: begin
        sum_nxt   = acc[UTIL_W] ? '1 : acc[UTIL_W-1:0];
        sched_nxt = (sum_nxt <= bound_for(count_r));
        i_nxt     = '0;
        ct_nxt    = '0;
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (count_r <= CNT_W'(1)) begin
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_SORT_LDI;
        end
      end

      S_SORT_LDI: begin
        mem_re    = 1'b1;
        mem_ra    = i_r[ADDR_W-1:0];
        state_nxt = S_SORT_GETI;
      end

      S_SORT_GETI: begin
        cur_nxt   = rd_data_r;
        j_nxt     = i_r + CNT_W'(1);
        state_nxt = S_SORT_RD;
      end

      S_SORT_RD: begin
        mem_re    = 1'b1;
        mem_ra    = j_r[ADDR_W-1:0];
        state_nxt = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        // entry i lives in cur_r during its pass
        if (cur_r.period > rd_data_r.period) begin
          mem_we  = 1'b1;
          mem_wa  = j_r[ADDR_W-1:0];
          mem_wd  = cur_r;
          cur_nxt = rd_data_r;
        end
        if (j_r + CNT_W'(1) == count_r) begin
          state_nxt = S_SORT_WB;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_SORT_RD;
        end
      end

      S_SORT_WB: begin
        mem_we = 1'b1;
        mem_wa = i_r[ADDR_W-1:0];
        mem_wd = cur_r;
        if (i_r + CNT_W'(2) == count_r) begin
          i_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SORT_LDI;
        end
      end

      S_OUT_RD: begin
        mem_re    = 1'b1;
        mem_ra    = i_r[ADDR_W-1:0];
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        ct_nxt        = ct_sat;
        out_valid_nxt = 1'b1;
        out_idx_nxt   = rd_data_r.index;
        out_ct_nxt    = ct_sat;
        out_wait_nxt  = ct_sat - CT_W'(rd_data_r.burst);
        out_miss_nxt  = (ct_sat > CT_W'(rd_data_r.deadline));
        out_last_nxt  = (i_r + CNT_W'(1) == count_r);
        state_nxt     = S_OUT_HOLD;
      end

      S_OUT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            sum_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    term_r     <= term_nxt;
    sched_r    <= sched_nxt;
    last_r     <= last_nxt;
    per_r      <= per_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cur_r      <= cur_nxt;
    ct_r       <= ct_nxt;
    out_idx_r  <= out_idx_nxt;
    out_ct_r   <= out_ct_nxt;
    out_wait_r <= out_wait_nxt;
    out_miss_r <= out_miss_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_task_index      = out_idx_r;
  assign out_completion_time = out_ct_r;
  assign out_waiting_time    = out_wait_r;
  assign out_deadline_missed = out_miss_r;
  assign out_utilization     = sum_r;
  assign out_schedulable     = sched_r;
  assign out_last_result     = out_last_r;

endmodule

`default_nettype wire
